@@ rtl/lz77d_pkg.sv @@
// ----------------------------------------------------------------------------
// lz77d_pkg
// Types and constants shared by the LZ77 type 0x10 decompressor modules.
// ----------------------------------------------------------------------------
package lz77d_pkg;

	// header magic byte and token field constants
	localparam logic [7:0] MAGIC_BYTE = 8'h10;
	localparam int         REM_W      = 24;     // declared output length
	localparam int         RUN_W      = 5;      // copy run length, 1..18
	localparam int         DIST_W     = 13;     // copy distance, 1..4096
	localparam logic [4:0] LEN_BIAS   = 5'd3;
	localparam logic [3:0] GROUP_SIZE = 4'd8;   // items governed by one flag byte

	// parser phase
	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_LEN0,
		PH_LEN1,
		PH_LEN2,
		PH_FLAG,
		PH_ITEM,
		PH_TOKLO,
		PH_IDLE
	} phase_t;

	// command kinds passed from the parser to the copy engine
	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       stream_end;
		logic       header_error;
	} out_item_t;

	// one decoded command: a literal, a copy run or a header error
	typedef struct packed {
		cmd_kind_t           kind;
		logic [7:0]          data;
		logic [RUN_W-1:0]    count;
		logic [DIST_W-1:0]   offset;
		logic                stream_last;  // command completes the declared length
		logic                fresh;        // first data command of a stream
	} cmd_t;

endpackage

@@ rtl/lz77d_fifo.sv @@
// ----------------------------------------------------------------------------
// lz77d_fifo
// Small register FIFO with occupancy count; used for commands and results.
// ----------------------------------------------------------------------------
module lz77d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = mem_q[rd_q];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

@@ rtl/lz77d_front.sv @@
// ----------------------------------------------------------------------------
// lz77d_front
// Stream parser: header, flag groups and tokens become literal, copy and
// error commands. Tracks the remaining output length to clip the last run.
// ----------------------------------------------------------------------------
module lz77d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  lz77d_pkg::in_item_t item,
	output logic               cmd_push,
	output lz77d_pkg::cmd_t    cmd
);
	import lz77d_pkg::*;

	phase_t             phase_q, phase_d, ph;
	logic [REM_W-1:0]   rem_q, rem_d, rem_new;
	logic [7:0]         flags_q, flags_d;
	logic [3:0]         left_q, left_d, left_n;
	logic [7:0]         th_q, th_d;
	logic               fresh_q, fresh_d;
	logic               adv;
	logic [RUN_W-1:0]   run_len;
	logic [RUN_W-1:0]   run_cnt;
	logic [7:0]         b;

	assign b       = item.in_byte;
	assign ph      = item.stream_start ? PH_MAGIC : phase_q;
	assign run_len = {1'b0, th_q[7:4]} + LEN_BIAS;
	assign run_cnt = (rem_q < REM_W'(run_len)) ? rem_q[RUN_W-1:0] : run_len;

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			rem_q   <= '0;
			flags_q <= '0;
			left_q  <= '0;
			th_q    <= '0;
			fresh_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			flags_q <= flags_d;
			left_q  <= left_d;
			th_q    <= th_d;
			fresh_q <= fresh_d;
		end
	end

	// decode one accepted byte
	always_comb begin
		phase_d  = phase_q;
		rem_d    = rem_q;
		flags_d  = flags_q;
		left_d   = left_q;
		th_d     = th_q;
		fresh_d  = fresh_q;
		adv      = 1'b0;
		rem_new  = rem_q;
		left_n   = left_q;
		cmd_push = 1'b0;
		cmd      = '0;
		cmd.kind  = CMD_LIT;
		cmd.count = RUN_W'(1);
		cmd.fresh = fresh_q;
		if (take) begin
			unique case (ph)
				PH_MAGIC: begin
					if (b != MAGIC_BYTE) begin
						cmd_push = 1'b1;
						cmd.kind = CMD_ERR;
						phase_d  = PH_IDLE;
					end else begin
						rem_d   = '0;
						phase_d = PH_LEN0;
						fresh_d = 1'b1;
					end
				end
				PH_LEN0: begin
					rem_d   = {16'd0, b};
					phase_d = PH_LEN1;
				end
				PH_LEN1: begin
					rem_d   = {8'd0, b, rem_q[7:0]};
					phase_d = PH_LEN2;
				end
				PH_LEN2: begin
					rem_d   = {b, rem_q[15:0]};
					phase_d = ({b, rem_q[15:0]} == '0) ? PH_IDLE : PH_FLAG;
				end
				PH_FLAG: begin
					flags_d = b;
					left_d  = GROUP_SIZE;
					phase_d = PH_ITEM;
				end
				PH_ITEM: begin
					if (flags_q[7]) begin
						th_d    = b;
						phase_d = PH_TOKLO;
					end else begin
						rem_new         = rem_q - 1'b1;
						cmd_push        = 1'b1;
						cmd.kind        = CMD_LIT;
						cmd.data        = b;
						cmd.stream_last = (rem_new == '0);
						fresh_d         = 1'b0;
						adv             = 1'b1;
					end
				end
				PH_TOKLO: begin
					rem_new         = rem_q - REM_W'(run_cnt);
					cmd_push        = 1'b1;
					cmd.kind        = CMD_COPY;
					cmd.count       = run_cnt;
					cmd.offset      = DIST_W'({th_q[3:0], b}) + 1'b1;
					cmd.stream_last = (rem_new == '0);
					fresh_d         = 1'b0;
					adv             = 1'b1;
				end
				PH_IDLE: begin
				end
				default: begin
				end
			endcase
		end

		// step to the next item of the flag group
		if (adv) begin
			left_n  = (left_q != '0) ? left_q - 1'b1 : left_q;
			flags_d = {flags_q[6:0], 1'b0};
			left_d  = left_n;
			rem_d   = rem_new;
			if (rem_new == '0) begin
				phase_d = PH_IDLE;
			end else begin
				phase_d = (left_n == '0) ? PH_FLAG : PH_ITEM;
			end
		end
	end

endmodule

@@ rtl/lz77d_back.sv @@
// ----------------------------------------------------------------------------
// lz77d_back
// Copy engine: expands commands into bytes, one per cycle while the result
// queue has room, through the history window. Issue stage reads the window;
// second stage resolves the byte, writes it back and pushes the result.
// ----------------------------------------------------------------------------
module lz77d_back #(
	parameter int WINDOW_DEPTH = 4096,
	parameter int OUT_DEPTH    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  lz77d_pkg::cmd_t             cmd,
	output logic                        cmd_pop,
	input  logic [$clog2(OUT_DEPTH):0]  out_count,
	output logic                        out_push,
	output lz77d_pkg::out_item_t        out_item
);
	import lz77d_pkg::*;

	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int PW  = AW + 1;
	localparam int OCW = $clog2(OUT_DEPTH) + 1;

	logic [7:0]       win_q [WINDOW_DEPTH];
	logic [AW-1:0]    wp_q;
	logic [PW-1:0]    prod_q;
	logic [RUN_W-1:0] j_q;

	logic             issue;
	logic             last;
	logic             use_fresh;
	logic [AW-1:0]    eff_wp;
	logic [PW-1:0]    eff_prod;
	logic [AW-1:0]    raddr;
	logic             too_far;
	logic             fwd;
	logic             is_data;

	logic             valid_s2;
	logic [7:0]       byte_s2;
	logic             from_mem_s2;
	logic             fwd_s2;
	logic [7:0]       fwd_byte_s2;
	logic [7:0]       rdata_s2;
	logic [AW-1:0]    waddr_s2;
	logic             we_s2;
	logic             run_end_s2;
	logic             stream_end_s2;
	logic             herr_s2;
	logic [7:0]       byte_res;

	// issue when a command waits and the result queue has room for it
	assign issue     = !cmd_empty &&
		((OCW'(out_count) + OCW'(valid_s2)) < OCW'(OUT_DEPTH));
	assign last      = ((j_q + 1'b1) == cmd.count);
	assign cmd_pop   = issue && last;
	assign use_fresh = cmd.fresh && (j_q == '0);
	assign eff_wp    = use_fresh ? '0 : wp_q;
	assign eff_prod  = use_fresh ? '0 : prod_q;
	assign raddr     = eff_wp - AW'(cmd.offset);
	assign too_far   = (PW'(cmd.offset) > eff_prod);
	assign fwd       = valid_s2 && we_s2 && (waddr_s2 == raddr);
	assign is_data   = (cmd.kind == CMD_LIT) || (cmd.kind == CMD_COPY);

	// resolve the second-stage byte
	assign byte_res = from_mem_s2 ? (fwd_s2 ? fwd_byte_s2 : rdata_s2) : byte_s2;

	assign out_push              = valid_s2;
	assign out_item.out_byte     = byte_res;
	assign out_item.run_end      = run_end_s2;
	assign out_item.stream_end   = stream_end_s2;
	assign out_item.header_error = herr_s2;

	// advance run counter, window pointer and produced count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			wp_q     <= '0;
			prod_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (issue) begin
				j_q <= last ? '0 : j_q + 1'b1;
				if (is_data) begin
					wp_q   <= eff_wp + 1'b1;
					prod_q <= (eff_prod == PW'(WINDOW_DEPTH)) ? eff_prod : eff_prod + 1'b1;
				end
			end
		end
	end

	// load the second stage
	always_ff @(posedge clk) begin
		if (issue) begin
			waddr_s2      <= eff_wp;
			we_s2         <= is_data;
			run_end_s2    <= last;
			stream_end_s2 <= last && cmd.stream_last && is_data;
			herr_s2       <= (cmd.kind == CMD_ERR);
			fwd_s2        <= fwd;
			fwd_byte_s2   <= byte_res;
			from_mem_s2   <= (cmd.kind == CMD_COPY) && !too_far;
			byte_s2       <= (cmd.kind == CMD_LIT) ? cmd.data : 8'd0;
		end
	end

	// history window: read at issue, write at second stage
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s2 <= win_q[raddr];
		end
		if (valid_s2 && we_s2) begin
			win_q[waddr_s2] <= byte_res;
		end
	end

endmodule

@@ rtl/lz77_type10_decompressor.sv @@
// ----------------------------------------------------------------------------
// Path: a command crosses the command queue, copy engine second stage and
// result queue. Throughput: one input byte per cycle while the command queue
// has room; results leave at one byte per cycle while the result queue has
// room, set by the single window read port; a copy token expands bytewise.
// Reset: asynchronous; the parser awaits a magic byte, queues empty, window
// contents are left as they are and never used before being written.
// ----------------------------------------------------------------------------
// lz77_type10_decompressor
// LZ77 type 0x10 stream decompressor: parser, command queue, copy engine
// with 4096-byte history window, and result queue.
// ----------------------------------------------------------------------------
module lz77_type10_decompressor #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  lz77d_pkg::in_item_t   item,
	output logic                  empty,
	input  logic                  pop,
	output lz77d_pkg::out_item_t  result
);
	import lz77d_pkg::*;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	logic                         take;
	logic                         cmd_push;
	cmd_t                         cmd_in;
	cmd_t                         cmd_head;
	logic                         cmd_full;
	logic                         cmd_empty;
	logic                         cmd_pop;
	logic [$clog2(CMD_DEPTH):0]   cmd_count;
	logic                         out_push;
	out_item_t                    out_item;
	logic                         out_full;
	logic [$clog2(OUT_DEPTH):0]   out_count;

	// accept a byte whenever the command queue can take one
	assign full = cmd_full;
	assign take = push && !cmd_full;

	lz77d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	lz77d_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	lz77d_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.OUT_DEPTH    (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty || (cmd_count == '0)),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	lz77d_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_item),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty),
		.count  (out_count)
	);

	// the copy engine reserves room, so the result queue never overflows
	logic unused_out_full;
	assign unused_out_full = out_full;

endmodule

@@ bench/tb_lz77_type10_decompressor.sv @@
// ----------------------------------------------------------------------------
// tb_lz77_type10_decompressor
// Feeds LZ77 type 0x10 streams through the decompressor byte by byte: a short
// directed set of corner streams, one long stream of longest copies, then
// random well-formed streams mixed with broken headers, cut-off
// streams and noise. A scoreboard decodes every accepted request itself and
// checks each popped output byte, field by field, in order.
// ----------------------------------------------------------------------------
module tb_lz77_type10_decompressor;
	import lz77d_pkg::*;

	localparam int WINDOW = 4096;

	// Decoder mirror plus the queue of output bytes still owed by the block.
	class lz_scoreboard;
		out_item_t   owed[$];
		logic [7:0]  window [WINDOW];
		logic [11:0] wr_ptr;
		logic [23:0] remaining;
		logic [12:0] produced;
		logic [7:0]  flags;
		logic [3:0]  flags_left;
		phase_t      phase;
		logic [7:0]  tok_high;
		int          errors;
		int          checked;
		int          bad_headers;

		function new();
			errors      = 0;
			checked     = 0;
			bad_headers = 0;
			restart();
		endfunction

		// drop all per-stream state; window contents stay as they are
		function void restart();
			wr_ptr     = '0;
			remaining  = '0;
			produced   = '0;
			flags      = '0;
			flags_left = '0;
			tok_high   = '0;
			phase      = PH_MAGIC;
		endfunction

		function void emit_byte(logic [7:0] v, ref out_item_t run[$]);
			out_item_t o;
			window[wr_ptr] = v;
			wr_ptr = wr_ptr + 12'd1;
			if (produced < WINDOW)
				produced = produced + 13'd1;
			remaining = remaining - 24'd1;
			o.out_byte     = v;
			o.run_end      = 1'b0;
			o.stream_end   = (remaining == 0);
			o.header_error = 1'b0;
			run = {run, o};
		endfunction

		function void advance_item();
			flags = flags << 1;
			if (flags_left != 0)
				flags_left = flags_left - 4'd1;
			if (remaining == 0)
				phase = PH_IDLE;
			else
				phase = (flags_left == 0) ? PH_FLAG : PH_ITEM;
		endfunction

		// Decode one accepted request and queue the output bytes it causes.
		function void note_request(in_item_t req);
			out_item_t   run[$];
			out_item_t   err;
			logic [7:0]  b;
			logic [12:0] offset;
			logic [11:0] idx;
			logic [7:0]  v;
			int          len;
			b = req.in_byte;
			if (req.stream_start)
				restart();
			case (phase)
				PH_MAGIC: begin
					if (b != MAGIC_BYTE) begin
						err.out_byte     = 8'h00;
						err.run_end      = 1'b1;
						err.stream_end   = 1'b0;
						err.header_error = 1'b1;
						run = {run, err};
						phase = PH_IDLE;
					end else begin
						remaining = '0;
						phase = PH_LEN0;
					end
				end
				PH_LEN0: begin
					remaining = {16'h0, b};
					phase = PH_LEN1;
				end
				PH_LEN1: begin
					remaining[15:8] = b;
					phase = PH_LEN2;
				end
				PH_LEN2: begin
					remaining[23:16] = b;
					phase = (remaining == 0) ? PH_IDLE : PH_FLAG;
				end
				PH_FLAG: begin
					flags = b;
					flags_left = GROUP_SIZE;
					phase = PH_ITEM;
				end
				PH_ITEM: begin
					if (flags[7]) begin
						tok_high = b;
						phase = PH_TOKLO;
					end else begin
						emit_byte(b, run);
						advance_item();
					end
				end
				PH_TOKLO: begin
					len    = int'(tok_high[7:4]) + int'(LEN_BIAS);
					offset = {1'b0, tok_high[3:0], b} + 13'd1;
					for (int j = 0; j < len && remaining != 0; j++) begin
						// reach before the stream start reads as zero
						idx = wr_ptr - offset[11:0];
						v = (offset <= produced) ? window[idx] : 8'h00;
						emit_byte(v, run);
					end
					advance_item();
				end
				default: ;
			endcase
			if (run.size() != 0)
				run[run.size() - 1].run_end = 1'b1;
			foreach (run[i])
				owed = {owed, run[i]};
		endfunction

		function void report_field(string name, logic [7:0] want, logic [7:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		endfunction

		// Compare one popped output byte with the oldest owed one.
		function void check_output(out_item_t got);
			out_item_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: output with nothing owed: expected none, actual %0h",
					$time, got);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (want.header_error)
				bad_headers++;
			if (got.out_byte !== want.out_byte)
				report_field("out_byte", want.out_byte, got.out_byte);
			if (got.run_end !== want.run_end)
				report_field("run_end", want.run_end, got.run_end);
			if (got.stream_end !== want.stream_end)
				report_field("stream_end", want.stream_end, got.stream_end);
			if (got.header_error !== want.header_error)
				report_field("header_error", want.header_error, got.header_error);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void close_out();
			if (owed.size() != 0) begin
				errors++;
				$display("%0t: %0d output bytes never arrived: expected 0, actual %0d",
					$time, owed.size(), owed.size());
			end
		endfunction
	endclass

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	lz_scoreboard sb = new();

	int          burst_left = 0;
	int          req_count  = 0;
	int          streams    = 0;
	logic [4:0]  rx_slot    = '0;
	logic [31:0] rx_pattern = '1;

	lz77_type10_decompressor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hang guard.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Pop side: check on each accepted output, stall on a rotating pattern.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_output(result);
		rx_slot <= rx_slot + 5'd1;
		if (rx_slot == 5'd31) begin
			case ($urandom_range(0, 3))
				0: rx_pattern <= '1;
				1: rx_pattern <= $urandom;
				2: rx_pattern <= $urandom | $urandom;
				default: rx_pattern <= ($urandom & $urandom) | 32'h1;
			endcase
		end
		pop <= rx_pattern[rx_slot];
	end

	// Push one request; open a random gap when the current burst runs out.
	task automatic send_req(input logic [7:0] b, input logic s);
		int unsigned gap;
		in_item_t    req;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 48 : int'($urandom_range(1, 12));
		end
		req.in_byte      = b;
		req.stream_start = s;
		item <= req;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(req);
		burst_left--;
		req_count++;
	endtask

	// Hold the sender until every owed output byte has been popped.
	task automatic drain_outputs();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// Send a well-formed stream of the given output length with random items.
	task automatic send_stream(input int unsigned out_len, input int unsigned tok_pct,
			input bit full_runs, input bit trailer);
		logic [23:0] len24;
		logic [7:0]  flag_byte;
		logic [3:0]  lnib;
		logic [11:0] dfield;
		int unsigned made;
		int unsigned reach;
		len24 = 24'(out_len);
		made = 0;
		streams++;
		send_req(MAGIC_BYTE, 1'b1);
		send_req(len24[7:0], 1'b0);
		send_req(len24[15:8], 1'b0);
		send_req(len24[23:16], 1'b0);
		while (made < out_len) begin
			for (int k = 0; k < 8; k++)
				flag_byte[k] = ($urandom_range(0, 99) < tok_pct);
			send_req(flag_byte, 1'b0);
			for (int k = 7; k >= 0 && made < out_len; k--) begin
				if (flag_byte[k]) begin
					lnib = full_runs ? 4'hF : 4'($urandom);
					reach = (made > WINDOW) ? WINDOW : made;
					if ($urandom_range(0, 19) == 0)
						dfield = 12'hFFF;
					else if (made > 0 && $urandom_range(0, 9) < 8)
						dfield = 12'($urandom_range(0, reach - 1));
					else
						dfield = 12'($urandom);
					send_req({lnib, dfield[11:8]}, 1'b0);
					send_req(dfield[7:0], 1'b0);
					made += int'(lnib) + 3;
				end else begin
					send_req(8'($urandom), 1'b0);
					made++;
				end
			end
		end
		// bytes past the declared length are ignored
		if (trailer)
			repeat ($urandom_range(1, 3)) send_req(8'($urandom), 1'b0);
	endtask

	initial begin
		logic [7:0] b;
		int         stop_at;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first byte after reset is the magic even without stream_start;
		// literal, overlapping copy at distance one, literal that ends it
		send_req(MAGIC_BYTE, 1'b0);
		send_req(8'h05, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h40, 1'b0);
		send_req(8'hFF, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		// longest copy reaching before the stream start, cut at the length
		send_req(MAGIC_BYTE, 1'b1);
		send_req(8'h04, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h80, 1'b0);
		send_req(8'hF0, 1'b0);
		send_req(8'h05, 1'b0);
		// restart inside a header with a bad magic, then idle until restart
		send_req(MAGIC_BYTE, 1'b1);
		send_req(8'hFF, 1'b0);
		send_req(8'hFF, 1'b0);
		send_req(8'h00, 1'b1);
		send_req(MAGIC_BYTE, 1'b0);
		// zero declared length gives nothing
		send_req(MAGIC_BYTE, 1'b1);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		streams += 3;
		drain_outputs();

		// long stream: longest copies back to back
		send_stream(600, 100, 1'b1, 1'b1);
		drain_outputs();

		// random mix, mostly well-formed streams
		stop_at = req_count + 100;
		while (req_count < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5:
					send_stream($urandom_range(1, 40), $urandom_range(20, 80), 1'b0,
						1'($urandom_range(0, 1)));
				6: begin
					// header with any length and up to ten further random bytes, mostly cut short
					streams++;
					send_req(MAGIC_BYTE, 1'b1);
					repeat (3) send_req(8'($urandom), 1'b0);
					repeat ($urandom_range(0, 10)) send_req(8'($urandom), 1'b0);
				end
				7: begin
					do b = 8'($urandom); while (b == MAGIC_BYTE);
					send_req(b, 1'b1);
					repeat ($urandom_range(0, 3)) send_req(8'($urandom), 1'b0);
				end
				8: begin
					repeat ($urandom_range(1, 8))
						send_req(8'($urandom), ($urandom_range(0, 7) == 0));
				end
				default: begin
					streams++;
					send_req(MAGIC_BYTE, 1'b1);
					repeat ($urandom_range(0, 3)) send_req(8'h00, 1'b0);
				end
			endcase
		end

		drain_outputs();
		repeat (20) @(posedge clk);
		sb.close_out();
		$display("Covered %0d requests over %0d streams: %0d output bytes checked, %0d bad headers.",
			req_count, streams, sb.checked, sb.bad_headers);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
